/* hdl/mi3_pkg.sv */
// ----------------------------------------------------------------------------
// mi3_pkg : shared types and constants for the 3x3 matrix inverse
// Element widths, cofactor index table and pipeline latencies.
// ----------------------------------------------------------------------------
package mi3_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int NE            = 9;    // elements per matrix
   localparam int EW            = 32;   // element width
   localparam int CW            = 65;   // exact cofactor width
   localparam int DW            = 99;   // exact determinant width
   localparam int QW            = 32;   // quotient bits kept
   localparam int RW            = DW + QW + 1;  // remainder width in the divider
   localparam int FRONT_LAT     = 6;
   localparam int LANE_LAT      = QW + 3;

   typedef logic signed [EW-1:0] elem_type;
   typedef logic signed [CW-1:0] cof_type;
   typedef logic signed [DW-1:0] det_type;
   typedef logic [3:0]           eidx_type;

   // cofactor k = e[A]*e[B] - e[C]*e[D]
   localparam eidx_type COF_A [NE] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
   localparam eidx_type COF_B [NE] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
   localparam eidx_type COF_C [NE] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
   localparam eidx_type COF_D [NE] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

endpackage

/* hdl/mi3_front.sv */
// ----------------------------------------------------------------------------
// mi3_front : cofactor and determinant pipeline
// Forms the nine cofactors exactly, then det = c8*e8 + c2*e6 + c5*e7.
// ----------------------------------------------------------------------------
module mi3_front (
   input  logic                clock,
   input  logic                en,
   input  mi3_pkg::elem_type   elem [mi3_pkg::NE],
   output mi3_pkg::cof_type    cof  [mi3_pkg::NE],
   output mi3_pkg::det_type    det
);
   import mi3_pkg::*;

   elem_type e1_ff [NE];
   elem_type e2_ff [NE];
   elem_type e3_ff [NE];
   logic signed [2*EW-1:0] pa_ff [NE];
   logic signed [2*EW-1:0] pb_ff [NE];
   cof_type  c3_ff [NE];
   cof_type  c4_ff [NE];
   cof_type  c5_ff [NE];
   cof_type  c6_ff [NE];
   logic signed [CW-1:0] ph_ff [3];
   logic signed [CW-1:0] pl_ff [3];
   det_type  t_ff [3];
   det_type  det_ff;
   elem_type mul_e [3];
   cof_type  mul_c [3];

   // det terms: c8*e8, c2*e6, c5*e7
   always_comb begin
      mul_c[0] = c3_ff[8];
      mul_c[1] = c3_ff[2];
      mul_c[2] = c3_ff[5];
      mul_e[0] = e3_ff[8];
      mul_e[1] = e3_ff[6];
      mul_e[2] = e3_ff[7];
   end

   // advance the pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NE; k++) begin
            e1_ff[k] <= elem[k];
            e2_ff[k] <= e1_ff[k];
            e3_ff[k] <= e2_ff[k];
            pa_ff[k] <= e1_ff[COF_A[k]] * e1_ff[COF_B[k]];
            pb_ff[k] <= e1_ff[COF_C[k]] * e1_ff[COF_D[k]];
            c3_ff[k] <= CW'(pa_ff[k]) - CW'(pb_ff[k]);
            c4_ff[k] <= c3_ff[k];
            c5_ff[k] <= c4_ff[k];
            c6_ff[k] <= c5_ff[k];
         end
         // split each 65-bit det-term cofactor into signed high and unsigned low halves
         for (int j = 0; j < 3; j++) begin
            ph_ff[j] <= $signed(mul_c[j][CW-1:EW]) * mul_e[j];
            pl_ff[j] <= $signed({1'b0, mul_c[j][EW-1:0]}) * mul_e[j];
            t_ff[j]  <= (DW'(ph_ff[j]) <<< EW) + DW'(pl_ff[j]);
         end
         det_ff <= t_ff[0] + t_ff[1] + t_ff[2];
      end
   end

   assign cof = c6_ff;
   assign det = det_ff;

endmodule

/* hdl/mi3_div_lane.sv */
// ----------------------------------------------------------------------------
// mi3_div_lane : one inverse element, (cof << 2F) / det, saturated
// Restoring division, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module mi3_div_lane #(
   parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               en,
   input  mi3_pkg::cof_type   cof,
   input  mi3_pkg::det_type   det,
   output mi3_pkg::elem_type  quo
);
   import mi3_pkg::*;

   localparam int NW = CW + 2 * FRAC_BITS;

   logic [NW-1:0]  nmag_ff;
   logic [DW-1:0]  dm0_ff;
   logic           neg0_ff;
   logic           zero0_ff;
   logic [RW-1:0]  rem_ff  [QW+1];
   logic [QW-1:0]  q_ff    [QW+1];
   logic [DW-1:0]  dmag_ff [QW+1];
   logic           neg_ff  [QW+1];
   logic           zero_ff [QW+1];
   logic           ovf_ff  [QW+1];
   elem_type       quo_ff;
   logic [CW-1:0]  cmag;
   logic [DW-1:0]  dmag;

   // magnitudes
   assign cmag = cof[CW-1] ? CW'(-cof) : CW'(cof);
   assign dmag = det[DW-1] ? DW'(-det) : DW'(det);

   // take magnitudes, then check the quotient fits in 32 bits
   always_ff @(posedge clock) begin
      if (en) begin
         nmag_ff     <= NW'(cmag) << (2 * FRAC_BITS);
         dm0_ff      <= dmag;
         neg0_ff     <= cof[CW-1] ^ det[DW-1];
         zero0_ff    <= (det == '0);
         rem_ff[0]   <= RW'(nmag_ff);
         q_ff[0]     <= '0;
         dmag_ff[0]  <= dm0_ff;
         neg_ff[0]   <= neg0_ff;
         zero_ff[0]  <= zero0_ff;
         ovf_ff[0]   <= RW'(nmag_ff) >= (RW'(dm0_ff) << QW);
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar s = 0; s < QW; s++) begin : g_stage
      localparam int BI = QW - 1 - s;
      logic [RW:0] sh;
      logic [RW:0] trial;
      assign sh    = (RW + 1)'(dmag_ff[s]) << BI;
      assign trial = {1'b0, rem_ff[s]} - sh;
      always_ff @(posedge clock) begin
         if (en) begin
            dmag_ff[s+1] <= dmag_ff[s];
            neg_ff[s+1]  <= neg_ff[s];
            zero_ff[s+1] <= zero_ff[s];
            ovf_ff[s+1]  <= ovf_ff[s];
            if (!trial[RW]) begin
               rem_ff[s+1] <= trial[RW-1:0];
               q_ff[s+1]   <= q_ff[s] | (QW'(1) << BI);
            end else begin
               rem_ff[s+1] <= rem_ff[s];
               q_ff[s+1]   <= q_ff[s];
            end
         end
      end
   end

   // apply sign, saturate, zero for a singular matrix
   always_ff @(posedge clock) begin
      if (en) begin
         if (zero_ff[QW]) begin
            quo_ff <= '0;
         end else if (neg_ff[QW]) begin
            if (ovf_ff[QW] || q_ff[QW][QW-1]) quo_ff <= {1'b1, {(EW-1){1'b0}}};
            else quo_ff <= -$signed(q_ff[QW]);
         end else begin
            if (ovf_ff[QW] || q_ff[QW][QW-1]) quo_ff <= {1'b0, {(EW-1){1'b1}}};
            else quo_ff <= $signed(q_ff[QW]);
         end
      end
   end

   assign quo = quo_ff;

endmodule

/* hdl/matrix3_inverse.sv */
// ----------------------------------------------------------------------------
// matrix3_inverse : 3x3 matrix inverse by the adjugate, Q16.16 fixed point
//
//   channel | direction | payload
//   req_    | in        | tdata: src_e0..src_e8, 32 bits each
//   rsp_    | out       | tdata: inv_e0..inv_e8, 32 bits each
//
// One matrix is accepted per cycle while the output is not stalled. A matrix
// passes through the cofactor and determinant pipeline, then the nine
// division lanes, which form one quotient bit per stage. Reset clears only
// the valid chain. A stalled result holds the whole pipeline in place.
// ----------------------------------------------------------------------------
module matrix3_inverse #(
   parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [287:0]  req_tdata,   // src_e0 [31:0] .. src_e8 [287:256]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [287:0]  rsp_tdata    // inv_e0 [31:0] .. inv_e8 [287:256]
);
   import mi3_pkg::*;

   localparam int TOT = FRONT_LAT + LANE_LAT;

   logic           adv;
   logic [TOT-1:0] vld_ff;
   logic [TOT-1:0] vld_in;
   elem_type       elem [NE];
   cof_type        cof  [NE];
   det_type        det;
   elem_type       quo  [NE];

   // whole pipeline advances unless the output is held
   assign adv        = !vld_ff[TOT-1] || rsp_tready;
   assign req_tready = adv && !reset;
   assign rsp_tvalid = vld_ff[TOT-1];
   assign vld_in     = {vld_ff[TOT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // unpack request
   always_comb begin
      for (int k = 0; k < NE; k++) elem[k] = req_tdata[k*EW +: EW];
   end

   mi3_front u_front (
      .clock (clock),
      .en    (adv),
      .elem  (elem),
      .cof   (cof),
      .det   (det)
   );

   for (genvar k = 0; k < NE; k++) begin : g_lane
      mi3_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock (clock),
         .en    (adv),
         .cof   (cof[k]),
         .det   (det),
         .quo   (quo[k])
      );
      // merge lane results into the response
      assign rsp_tdata[k*EW +: EW] = quo[k];
   end

endmodule
